FILE: hdl/pgs_rle_pixel_decoder_core_defines.svh
// ----------------------------------------------------------------------------
// pgs_rle_pixel_decoder_core_defines
// Assertion macros used by the decoder core.
// ----------------------------------------------------------------------------
`ifndef PGS_RLE_PIXEL_DECODER_CORE_DEFINES_SVH
`define PGS_RLE_PIXEL_DECODER_CORE_DEFINES_SVH

// same-cycle implication, quiet during reset
`define PGS_ASSERT_NOW(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);

// next-cycle implication, quiet during reset
`define PGS_ASSERT_NEXT(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);

`endif

FILE: hdl/pgs_rle_pkg.sv
// ----------------------------------------------------------------------------
// pgs_rle_pkg
// Types and constants for the PGS run-length pixel decoder.
// ----------------------------------------------------------------------------
package pgs_rle_pkg;

  localparam int MAX_DIMENSION   = 4096;
  localparam int PALETTE_ENTRIES = 256;
  localparam int DIM_W           = $clog2(MAX_DIMENSION);
  localparam int ADDR_W          = 2 * DIM_W;
  localparam int RUN_W           = 14;
  localparam int PAL_W           = $clog2(PALETTE_ENTRIES);

  localparam logic [1:0] OP_DATA    = 2'd0;
  localparam logic [1:0] OP_PALETTE = 2'd1;
  localparam logic [1:0] OP_OBJECT  = 2'd2;

  localparam logic [1:0] REG_CANVAS_WIDTH  = 2'd0;
  localparam logic [1:0] REG_CANVAS_HEIGHT = 2'd1;

  localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(1920);
  localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(1080);

  localparam logic [7:0] CODE_KIND_MASK = 8'hC0;
  localparam logic [1:0] KIND_ZSHORT    = 2'b00;
  localparam logic [1:0] KIND_ZLONG     = 2'b01;
  localparam logic [1:0] KIND_CSHORT    = 2'b10;
  localparam logic [1:0] KIND_CLONG     = 2'b11;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_ESC,
    PH_ZLONG,
    PH_CSHORT,
    PH_CLONG,
    PH_CINDEX
  } phase_t;

  typedef struct packed {
    logic [1:0]       op;
    logic [7:0]       data_byte;
    logic             last_byte;
    logic [7:0]       palette_index;
    logic [7:0]       palette_gray;
    logic [DIM_W-1:0] object_x;
    logic [DIM_W-1:0] object_y;
  } in_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] pixel_address;
    logic [7:0]        pixel_value;
    logic [RUN_W-1:0]  run_length;
  } out_item_t;

  typedef struct packed {
    logic      emit;
    out_item_t item;
  } run_t;

endpackage

FILE: hdl/pgs_rle_decode.sv
// ----------------------------------------------------------------------------
// pgs_rle_decode
// Byte-wise RLE code state machine and run placement on the canvas.
// ----------------------------------------------------------------------------
module pgs_rle_decode (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           advance,
  input  pgs_rle_pkg::in_item_t          item,
  input  logic [7:0]                     pal_gray,
  input  logic [pgs_rle_pkg::DIM_W-1:0]  stride,
  input  logic [pgs_rle_pkg::ADDR_W-1:0] area_end,
  output pgs_rle_pkg::run_t              run
);

  localparam int AW = pgs_rle_pkg::ADDR_W;
  localparam int RW = pgs_rle_pkg::RUN_W;

  pgs_rle_pkg::phase_t phase, phase_next;
  logic [7:0]    code_byte, code_byte_next;
  logic [RW-1:0] run_count, run_count_next;
  logic [AW-1:0] line_start, line_start_next;
  logic [AW-1:0] write_addr, write_addr_next;

  logic          req;
  logic [RW-1:0] req_len;
  logic [7:0]    req_value;
  logic [AW-1:0] remain;
  logic [AW:0]   end_sum;
  logic [AW:0]   line_sum;
  logic [AW:0]   obj_pos;
  logic [RW-1:0] long_len;

  assign long_len = {code_byte[5:0], item.data_byte};
  assign line_sum = {1'b0, line_start} + (AW+1)'(stride);
  assign obj_pos  = (AW+1)'(item.object_y) * (AW+1)'(stride) + (AW+1)'(item.object_x);

  // next state
  always_comb begin
    phase_next      = phase;
    code_byte_next  = code_byte;
    run_count_next  = run_count;
    line_start_next = line_start;
    req             = 1'b0;
    req_len         = '0;
    req_value       = '0;
    case (item.op)
      pgs_rle_pkg::OP_DATA: begin
        case (phase)
          pgs_rle_pkg::PH_IDLE: begin
            if (item.data_byte != 8'd0) begin
              req       = 1'b1;
              req_len   = RW'(1);
              req_value = pal_gray;
            end else begin
              phase_next = pgs_rle_pkg::PH_ESC;
            end
          end
          pgs_rle_pkg::PH_ESC: begin
            phase_next = pgs_rle_pkg::PH_IDLE;
            if (item.data_byte == 8'd0) begin
              // end of line: drop one canvas row, saturate at canvas end
              line_start_next = (line_sum > {1'b0, area_end}) ? area_end
                                                              : line_sum[AW-1:0];
            end else begin
              code_byte_next = item.data_byte;
              case (item.data_byte[7:6])
                pgs_rle_pkg::KIND_ZLONG:  phase_next = pgs_rle_pkg::PH_ZLONG;
                pgs_rle_pkg::KIND_CSHORT: phase_next = pgs_rle_pkg::PH_CSHORT;
                pgs_rle_pkg::KIND_CLONG:  phase_next = pgs_rle_pkg::PH_CLONG;
                default: begin
                  req     = 1'b1;
                  req_len = RW'(item.data_byte);
                end
              endcase
            end
          end
          pgs_rle_pkg::PH_ZLONG: begin
            phase_next = pgs_rle_pkg::PH_IDLE;
            req        = 1'b1;
            req_len    = long_len;
          end
          pgs_rle_pkg::PH_CSHORT: begin
            phase_next = pgs_rle_pkg::PH_IDLE;
            req        = 1'b1;
            req_len    = RW'(code_byte[5:0]);
            req_value  = pal_gray;
          end
          pgs_rle_pkg::PH_CLONG: begin
            phase_next     = pgs_rle_pkg::PH_CINDEX;
            run_count_next = long_len;
          end
          pgs_rle_pkg::PH_CINDEX: begin
            phase_next = pgs_rle_pkg::PH_IDLE;
            req        = 1'b1;
            req_len    = run_count;
            req_value  = pal_gray;
          end
          default: phase_next = pgs_rle_pkg::PH_IDLE;
        endcase
        // truncated code at the object's end is dropped
        if (item.last_byte) begin
          phase_next = pgs_rle_pkg::PH_IDLE;
        end
      end
      pgs_rle_pkg::OP_OBJECT: begin
        phase_next      = pgs_rle_pkg::PH_IDLE;
        code_byte_next  = '0;
        run_count_next  = '0;
        line_start_next = (obj_pos > {1'b0, area_end}) ? area_end : obj_pos[AW-1:0];
      end
      default: ;
    endcase
  end

  // run placement and clamping
  always_comb begin
    remain          = area_end - write_addr;
    end_sum         = {1'b0, write_addr} + (AW+1)'(req_len);
    run.emit        = 1'b0;
    run.item.pixel_address = write_addr;
    run.item.pixel_value   = req_value;
    run.item.run_length    = req_len;
    write_addr_next = write_addr;
    if (line_start_next != line_start || (item.op == pgs_rle_pkg::OP_OBJECT) ||
        (item.op == pgs_rle_pkg::OP_DATA && phase == pgs_rle_pkg::PH_ESC &&
         item.data_byte == 8'd0)) begin
      write_addr_next = line_start_next;
    end else if (req && req_len != '0 && write_addr < area_end) begin
      run.emit = 1'b1;
      if (AW'(req_len) > remain) begin
        run.item.run_length = remain[RW-1:0];
      end
      write_addr_next = (end_sum > {1'b0, area_end}) ? area_end : end_sum[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= pgs_rle_pkg::PH_IDLE;
      code_byte  <= '0;
      run_count  <= '0;
      line_start <= '0;
      write_addr <= '0;
    end else if (advance) begin
      phase      <= phase_next;
      code_byte  <= code_byte_next;
      run_count  <= run_count_next;
      line_start <= line_start_next;
      write_addr <= write_addr_next;
    end
  end

endmodule

FILE: hdl/pgs_rle_pixel_decoder_core.sv
// ----------------------------------------------------------------------------
// pgs_rle_pixel_decoder_core
// PGS subtitle RLE decoder: palette, input register, decode, result register.
// ----------------------------------------------------------------------------
// Path: an accepted input goes into the input register with the palette read,
// then is decoded into the result register.
// Throughput: one item per cycle; a stalled result holds the input register.
// Reset: synchronous, active high; clears decode state, addresses and canvas
// registers (1920 x 1080). Palette contents stay undefined until written.
`include "pgs_rle_pixel_decoder_core_defines.svh"

module pgs_rle_pixel_decoder_core (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  pgs_rle_pkg::in_item_t  in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output pgs_rle_pkg::out_item_t out_data,
  input  logic                   cfg_write,
  input  logic [1:0]             cfg_index,
  input  logic [pgs_rle_pkg::DIM_W-1:0] cfg_data
);

  localparam int DW = pgs_rle_pkg::DIM_W;

  logic [7:0] palette [pgs_rle_pkg::PALETTE_ENTRIES];

  logic [DW-1:0]                  stride;
  logic [DW-1:0]                  rows;
  logic [pgs_rle_pkg::ADDR_W-1:0] area_end;

  pgs_rle_pkg::in_item_t s1_item;
  logic                  s1_valid;
  logic [7:0]            pal_gray;
  logic                  accept;
  logic                  advance;
  pgs_rle_pkg::run_t     run;

  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      stride <= pgs_rle_pkg::WIDTH_RESET;
      rows   <= pgs_rle_pkg::HEIGHT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        pgs_rle_pkg::REG_CANVAS_WIDTH:  stride <= cfg_data;
        pgs_rle_pkg::REG_CANVAS_HEIGHT: rows   <= cfg_data;
        default: ;
      endcase
    end
  end

  // canvas size held in a register behind the width and height registers
  always_ff @(posedge clk) begin
    area_end <= {{DW{1'b0}}, stride} * {{DW{1'b0}}, rows};
  end

  // palette write and read both at acceptance, so order is kept
  always_ff @(posedge clk) begin
    if (accept) begin
      if (in_data.op == pgs_rle_pkg::OP_PALETTE) begin
        palette[in_data.palette_index] <= in_data.palette_gray;
      end
      pal_gray <= palette[in_data.data_byte];
      s1_item  <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  pgs_rle_decode u_decode (
    .clk      (clk),
    .rst      (rst),
    .advance  (advance),
    .item     (s1_item),
    .pal_gray (pal_gray),
    .stride   (stride),
    .area_end (area_end),
    .run      (run)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= run.emit;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && run.emit) begin
      out_data <= run.item;
    end
  end

  `PGS_ASSERT_NOW(a_run_nonzero, clk, rst, out_valid, out_data.run_length != '0, "zero-length run emitted")
  `PGS_ASSERT_NOW(a_ready_when_empty, clk, rst, !s1_valid, in_ready, "input blocked with empty stage")
  `PGS_ASSERT_NEXT(a_stage_holds, clk, rst, s1_valid && out_valid && !out_ready, s1_valid, "stalled item lost")

endmodule

FILE: test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Testbench for the PGS run-length pixel decoder. Sends palette writes,
// object starts and coded bytes over the valid/ready input, predicts every
// pixel run in a scoreboard and checks each run in order as it leaves the
// block. Canvas sizes change between phases, and both sides of the block
// idle and stall at varying rates.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] OP_UNUSED      = 2'd3;
  localparam logic [7:0] ESCAPE         = 8'h00;
  localparam int         QUIET_LIMIT    = 5000;
  localparam int         HOLD_CYCLES    = 400;
  localparam int         SETTLE_CYCLES  = 4;
  localparam int         PHASES         = 7;
  localparam int         PRESSURE_PHASE = 3;
  localparam int         PRESSURE_ITEMS = 60;

  typedef enum {
    PICK_PIXEL,
    PICK_EOL,
    PICK_ZSHORT,
    PICK_ZLONG,
    PICK_CSHORT,
    PICK_CLONG
  } code_pick_t;

  // Scoreboard: tracks decode state, palette and canvas, holds the runs due.
  class pixel_run_board;
    logic [pgs_rle_pkg::DIM_W-1:0] width  = pgs_rle_pkg::WIDTH_RESET;
    logic [pgs_rle_pkg::DIM_W-1:0] height = pgs_rle_pkg::HEIGHT_RESET;
    pgs_rle_pkg::phase_t           phase  = pgs_rle_pkg::PH_IDLE;
    logic [7:0]                    code   = '0;
    logic [pgs_rle_pkg::RUN_W-1:0] count  = '0;
    logic [7:0]                    gray  [pgs_rle_pkg::PALETTE_ENTRIES];
    bit                            known [pgs_rle_pkg::PALETTE_ENTRIES];
    int unsigned                   line_start = 0;
    int unsigned                   wr_addr    = 0;
    pgs_rle_pkg::out_item_t        runs_due [$];
    int                            errors = 0;

    function int unsigned dim(logic [pgs_rle_pkg::DIM_W-1:0] v);
      return (v > pgs_rle_pkg::MAX_DIMENSION - 1) ? pgs_rle_pkg::MAX_DIMENSION - 1
                                                  : v;
    endfunction

    function int unsigned canvas_end();
      return dim(width) * dim(height);
    endfunction

    function int unsigned clamp_end(int unsigned a);
      int unsigned e;
      e = canvas_end();
      return (a > e) ? e : a;
    endfunction

    // Clip the run at the canvas end; drop it when empty or off the canvas.
    function void put_run(logic [7:0] value, int unsigned n);
      int unsigned            e;
      int unsigned            len;
      pgs_rle_pkg::out_item_t r;
      e = canvas_end();
      if (n == 0 || wr_addr >= e) return;
      len = e - wr_addr;
      if (n < len) len = n;
      r.pixel_address = wr_addr[pgs_rle_pkg::ADDR_W-1:0];
      r.pixel_value   = value;
      r.run_length    = len[pgs_rle_pkg::RUN_W-1:0];
      runs_due.push_back(r);
      wr_addr = clamp_end(wr_addr + n);
    endfunction

    function bit reads_table(logic [7:0] b);
      return (phase == pgs_rle_pkg::PH_IDLE && b != ESCAPE) ||
             phase == pgs_rle_pkg::PH_CSHORT || phase == pgs_rle_pkg::PH_CINDEX;
    endfunction

    function void set_reg(logic [1:0] idx, logic [pgs_rle_pkg::DIM_W-1:0] v);
      case (idx)
        pgs_rle_pkg::REG_CANVAS_WIDTH:  width  = v;
        pgs_rle_pkg::REG_CANVAS_HEIGHT: height = v;
        default: ;
      endcase
    endfunction

    function void take_item(pgs_rle_pkg::in_item_t it);
      logic [7:0] b;
      b = it.data_byte;
      case (it.op)
        pgs_rle_pkg::OP_DATA: begin
          case (phase)
            pgs_rle_pkg::PH_IDLE: begin
              if (b != ESCAPE) put_run(gray[b], 1);
              else phase = pgs_rle_pkg::PH_ESC;
            end
            pgs_rle_pkg::PH_ESC: begin
              phase = pgs_rle_pkg::PH_IDLE;
              if (b == ESCAPE) begin
                line_start = clamp_end(line_start + dim(width));
                wr_addr    = line_start;
              end else begin
                code = b;
                case (b[7:6])
                  pgs_rle_pkg::KIND_ZLONG:  phase = pgs_rle_pkg::PH_ZLONG;
                  pgs_rle_pkg::KIND_CSHORT: phase = pgs_rle_pkg::PH_CSHORT;
                  pgs_rle_pkg::KIND_CLONG:  phase = pgs_rle_pkg::PH_CLONG;
                  default:                  put_run(8'd0, b);
                endcase
              end
            end
            pgs_rle_pkg::PH_ZLONG: begin
              phase = pgs_rle_pkg::PH_IDLE;
              put_run(8'd0, {code[5:0], b});
            end
            pgs_rle_pkg::PH_CSHORT: begin
              phase = pgs_rle_pkg::PH_IDLE;
              put_run(gray[b], code[5:0]);
            end
            pgs_rle_pkg::PH_CLONG: begin
              count = {code[5:0], b};
              phase = pgs_rle_pkg::PH_CINDEX;
            end
            pgs_rle_pkg::PH_CINDEX: begin
              phase = pgs_rle_pkg::PH_IDLE;
              put_run(gray[b], count);
            end
            default: phase = pgs_rle_pkg::PH_IDLE;
          endcase
          // drop any code left open at the object's last byte
          if (it.last_byte) phase = pgs_rle_pkg::PH_IDLE;
        end
        pgs_rle_pkg::OP_PALETTE: begin
          gray[it.palette_index]  = it.palette_gray;
          known[it.palette_index] = 1'b1;
        end
        pgs_rle_pkg::OP_OBJECT: begin
          line_start = clamp_end(it.object_y * dim(width) + it.object_x);
          wr_addr    = line_start;
          phase      = pgs_rle_pkg::PH_IDLE;
          code       = '0;
          count      = '0;
        end
        default: ;
      endcase
    endfunction

    function void match_run(pgs_rle_pkg::out_item_t got);
      pgs_rle_pkg::out_item_t want;
      if (runs_due.size() == 0) begin
        errors++;
        $display("%0t: run with none expected: address %0d value %0d length %0d",
                 $time, got.pixel_address, got.pixel_value, got.run_length);
        return;
      end
      want = runs_due.pop_front();
      if (got.pixel_address !== want.pixel_address || got.pixel_value !== want.pixel_value ||
          got.run_length !== want.run_length) begin
        errors++;
        $display("%0t: run mismatch: expected address %0d value %0d length %0d", $time,
                 want.pixel_address, want.pixel_value, want.run_length);
        $display("%0t: run mismatch: actual   address %0d value %0d length %0d", $time,
                 got.pixel_address, got.pixel_value, got.run_length);
      end
    endfunction
  endclass

  logic                          clk       = 1'b0;
  logic                          rst       = 1'b1;
  logic                          in_valid  = 1'b0;
  logic                          in_ready;
  pgs_rle_pkg::in_item_t         in_data   = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  pgs_rle_pkg::out_item_t        out_data;
  logic                          cfg_write = 1'b0;
  logic [1:0]                    cfg_index = pgs_rle_pkg::REG_CANVAS_WIDTH;
  logic [pgs_rle_pkg::DIM_W-1:0] cfg_data  = '0;

  pixel_run_board board = new;

  int items_sent = 0;
  int send_idle  = 0;
  int stall_pct  = 0;
  int cur_w      = 1920;
  int cur_h      = 1080;
  int hold_req   = 0;
  int hold_seen  = 0;
  int hold_left  = 0;
  int quiet      = 0;

  int phase_w     [PHASES] = '{4095, 1, 7, 640, 4095, 1, 1920};
  int phase_h     [PHASES] = '{4095, 1, 5, 480, 1, 4095, 1080};
  int phase_idle  [PHASES] = '{0, 88, 0, 20, 88, 20, 0};
  int phase_stall [PHASES] = '{0, 0, 88, 20, 0, 20, 0};
  int phase_items [PHASES] = '{250, 150, 200, 200, 200, 200, 100};

  logic [7:0] lead_codes [20] = '{
    8'hFF,
    8'h00, 8'h00,
    8'h00, 8'h3F,
    8'h00, 8'h7F, 8'hFF,
    8'h00, 8'hBF, 8'h00,
    8'h00, 8'hFF, 8'hFF, 8'h01,
    8'h00, 8'h40, 8'h00,
    8'h00, 8'hC1
  };

  pgs_rle_pixel_decoder_core DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Receiver: random stalls, plus one long hold-off on request.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) board.match_run(out_data);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet == QUIET_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic pgs_rle_pkg::in_item_t fresh_item(logic [1:0] op);
    logic [63:0]           r;
    pgs_rle_pkg::in_item_t it;
    r = {$urandom, $urandom};
    it = r[$bits(pgs_rle_pkg::in_item_t)-1:0];
    it.op = op;
    it.last_byte = 1'b0;
    return it;
  endfunction

  task automatic put_item(input pgs_rle_pkg::in_item_t it);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    board.take_item(it);
    if (it.op != OP_UNUSED) items_sent++;
  endtask

  task automatic send_palette(logic [7:0] idx, logic [7:0] value);
    pgs_rle_pkg::in_item_t it;
    it = fresh_item(pgs_rle_pkg::OP_PALETTE);
    it.palette_index = idx;
    it.palette_gray  = value;
    put_item(it);
  endtask

  task automatic send_object(int x, int y);
    pgs_rle_pkg::in_item_t it;
    it = fresh_item(pgs_rle_pkg::OP_OBJECT);
    it.object_x = x[pgs_rle_pkg::DIM_W-1:0];
    it.object_y = y[pgs_rle_pkg::DIM_W-1:0];
    put_item(it);
  endtask

  // Fill the palette entry first when this byte would look it up.
  task automatic send_data(logic [7:0] b, bit last);
    pgs_rle_pkg::in_item_t it;
    if (board.reads_table(b) && !board.known[b]) send_palette(b, 8'($urandom));
    it = fresh_item(pgs_rle_pkg::OP_DATA);
    it.data_byte = b;
    it.last_byte = last;
    put_item(it);
  endtask

  task automatic random_object();
    logic [7:0] codes_q [$];
    logic [5:0] hi;
    code_pick_t pick;
    int         n_codes;
    if ($urandom_range(99) < 85)
      send_object($urandom_range(0, cur_w - 1), $urandom_range(0, cur_h - 1));
    else
      send_object($urandom_range(0, pgs_rle_pkg::MAX_DIMENSION - 1),
                  $urandom_range(0, pgs_rle_pkg::MAX_DIMENSION - 1));
    n_codes = $urandom_range(1, 10);
    repeat (n_codes) begin
      pick = code_pick_t'($urandom_range(0, 5));
      hi = ($urandom_range(99) < 75) ? 6'd0 : 6'($urandom);
      if (pick != PICK_PIXEL) codes_q.push_back(ESCAPE);
      case (pick)
        PICK_PIXEL:  codes_q.push_back(8'($urandom_range(1, 255)));
        PICK_EOL:    codes_q.push_back(ESCAPE);
        PICK_ZSHORT: codes_q.push_back({pgs_rle_pkg::KIND_ZSHORT, 6'($urandom_range(1, 63))});
        PICK_ZLONG: begin
          codes_q.push_back({pgs_rle_pkg::KIND_ZLONG, hi});
          codes_q.push_back(8'($urandom));
        end
        PICK_CSHORT: begin
          codes_q.push_back({pgs_rle_pkg::KIND_CSHORT, 6'($urandom)});
          codes_q.push_back(8'($urandom));
        end
        default: begin
          codes_q.push_back({pgs_rle_pkg::KIND_CLONG, hi});
          codes_q.push_back(8'($urandom));
          codes_q.push_back(8'($urandom));
        end
      endcase
    end
    // cut some objects short, often in the middle of a code
    if ($urandom_range(99) < 12 && codes_q.size() > 1)
      codes_q = codes_q[0:$urandom_range(0, codes_q.size() - 2)];
    foreach (codes_q[i]) begin
      if ($urandom_range(99) < 4) send_palette(8'($urandom), 8'($urandom));
      send_data(codes_q[i], i == codes_q.size() - 1);
    end
  endtask

  task automatic noise_item();
    case ($urandom_range(0, 3))
      0: put_item(fresh_item(OP_UNUSED));
      1: send_data(8'($urandom), 1'($urandom));
      2: send_palette(8'($urandom), 8'($urandom));
      default:
        send_object($urandom_range(0, pgs_rle_pkg::MAX_DIMENSION - 1),
                    $urandom_range(0, pgs_rle_pkg::MAX_DIMENSION - 1));
    endcase
  endtask

  // Hold the input, wait for every run due, then let the pipeline settle.
  task automatic drain();
    in_valid <= 1'b0;
    while (board.runs_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [pgs_rle_pkg::DIM_W-1:0] v);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    board.set_reg(idx, v);
    cfg_write <= 1'b0;
  endtask

  initial begin
    int target;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: palette extremes, every code form, truncation, canvas end
    send_palette(8'h00, 8'hA5);
    send_palette(8'hFF, 8'hFF);
    send_palette(8'h01, 8'h00);
    send_object(0, 0);
    foreach (lead_codes[i]) send_data(lead_codes[i], i == 19);
    put_item(fresh_item(OP_UNUSED));
    send_object(pgs_rle_pkg::MAX_DIMENSION - 1, pgs_rle_pkg::MAX_DIMENSION - 1);
    send_data(8'h01, 1'b1);

    target = items_sent;
    for (int p = 0; p < PHASES; p++) begin
      drain();
      write_reg(pgs_rle_pkg::REG_CANVAS_WIDTH, phase_w[p][pgs_rle_pkg::DIM_W-1:0]);
      write_reg(pgs_rle_pkg::REG_CANVAS_HEIGHT, phase_h[p][pgs_rle_pkg::DIM_W-1:0]);
      cur_w = phase_w[p];
      cur_h = phase_h[p];
      stall_pct <= phase_stall[p];
      if (p == PRESSURE_PHASE) begin
        // block the output while the input keeps coming
        hold_req <= hold_req + 1;
        send_idle = 0;
        target += PRESSURE_ITEMS;
        while (items_sent < target) random_object();
      end
      send_idle = phase_idle[p];
      target += phase_items[p];
      while (items_sent < target) begin
        if ($urandom_range(99) < 80) random_object();
        else noise_item();
      end
    end

    drain();
    if (board.errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule

FILE: pgs_rle_pixel_decoder_core.f
+incdir+hdl
hdl/pgs_rle_pkg.sv
hdl/pgs_rle_decode.sv
hdl/pgs_rle_pixel_decoder_core.sv
test/tb.sv
